/* src/reaction_diffusion_stencil_step_assert.svh */
`ifndef REACTION_DIFFUSION_STENCIL_STEP_ASSERT_SVH
`define REACTION_DIFFUSION_STENCIL_STEP_ASSERT_SVH
// Checks that hold in the same cycle: when ante is true, cons must be true.
`define RDS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Checks that look ahead to the next cycle: when ante is true, cons must follow.
`define RDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

/* src/rds_pkg.sv */
`timescale 1ns / 1ps
package rds_pkg;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int VALUE_BITS_DEF = 20;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 18;

  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIFFUSION_U = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIFFUSION_V = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_FEED_RATE   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_KILL_RATE   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_TIME_STEP   = 3'd6;

  localparam int GW_BITS      = 11;
  localparam int ROW_BITS     = 16;
  localparam int GAIN_BITS    = 16;
  localparam int DT_BITS      = 18;
  localparam int COL_OUT_BITS = 10;

  localparam logic [GW_BITS-1:0]   GRID_WIDTH_RST  = 11'd256;
  localparam logic [ROW_BITS-1:0]  GRID_HEIGHT_RST = 16'd256;
  localparam logic [GAIN_BITS-1:0] DIFF_U_RST      = 16'd9175;
  localparam logic [GAIN_BITS-1:0] DIFF_V_RST      = 16'd3932;
  localparam logic [GAIN_BITS-1:0] FEED_RST        = 16'd1638;
  localparam logic [GAIN_BITS-1:0] KILL_RST        = 16'd3604;
  localparam logic [DT_BITS-1:0]   DT_RST          = 18'd65536;

  // Results per input item at most, and the 4 of the Laplacian as a shift.
  localparam int MAX_EMIT  = 4;
  localparam int LAP_SHIFT = 2;
endpackage

/* src/rds_ram.sv */
`timescale 1ns / 1ps
module rds_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* src/reaction_diffusion_stencil_step.sv */
`timescale 1ns / 1ps
// One Gray-Scott reaction-diffusion iteration over a grid streamed in raster order.
// The input channel (in_*) takes one cell per request: u and v, signed fixed point.
// The result channel (out_*) gives updated cells with their column and row; one
// input cell can cause up to four results, because border cells repeat the
// nearest interior result. out_tlast marks the last result of an input cell and
// out_tuser the final result of the grid. The user should write the registers
// through the cfg_* port only while the block is idle; the block itself does not
// enforce this. Writing the width or height restarts the frame. A cell that
// causes no result is accepted, then goes through line store read and write
// back. A cell that completes an interior cell also passes through the single
// shared multiplier, which does all eight products of the update one after
// another, then gives its results in turn. The two line stores are synchronous
// RAMs holding the last two rows. Results leave through an output register, so the
// next cell is accepted while the last result still waits; a stalled receiver holds
// the block in its emit phase. Reset clears the counters, window and registers to
// their defaults; line stores need no clearing, as entries are written before use.
`include "reaction_diffusion_stencil_step_assert.svh"
module reaction_diffusion_stencil_step #(
  parameter int MAX_WIDTH  = rds_pkg::MAX_WIDTH_DEF,
  parameter int FRAC_BITS  = rds_pkg::FRAC_BITS_DEF,
  parameter int VALUE_BITS = rds_pkg::VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // u_in, v_in (from bit 0 up), zero padded to whole bytes
  input  logic [((2*VALUE_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // out_col, out_row, u_new, v_new (from bit 0 up), zero padded to whole bytes
  output logic [((rds_pkg::COL_OUT_BITS+rds_pkg::ROW_BITS+2*VALUE_BITS+7)/8)*8-1:0] out_tdata,
  output logic out_tlast,  // run_end
  output logic out_tuser,  // frame_end
  input  logic cfg_we,
  input  logic [rds_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [rds_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import rds_pkg::*;

  localparam int VB     = VALUE_BITS;
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int CW     = $clog2(MAX_WIDTH + 1);
  localparam int GW     = (CW > GW_BITS) ? CW : GW_BITS;
  localparam int AW     = (VB + 6 > FRAC_BITS + 3) ? VB + 6 : FRAC_BITS + 3;
  localparam int BW     = (VB > DT_BITS + 1) ? VB : DT_BITS + 1;
  localparam int PW     = AW + BW;
  localparam int LW     = VB + 3;
  localparam int OUT_TW = ((COL_OUT_BITS + ROW_BITS + 2*VB + 7) / 8) * 8;

  localparam logic signed [AW-1:0] ONE_Q   = AW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] HALF_Q  = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [PW:0]   SAT_HI  = ((PW+1)'(1) << (VB - 1)) - (PW+1)'(1);
  localparam logic signed [PW:0]   SAT_LO  = -SAT_HI - (PW+1)'(1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_VV   = 4'd2;
  localparam logic [3:0] S_UV2  = 4'd3;
  localparam logic [3:0] S_P1   = 4'd4;
  localparam logic [3:0] S_P2   = 4'd5;
  localparam logic [3:0] S_P3   = 4'd6;
  localparam logic [3:0] S_P4   = 4'd7;
  localparam logic [3:0] S_DIFF = 4'd8;
  localparam logic [3:0] S_UN   = 4'd9;
  localparam logic [3:0] S_VN   = 4'd10;
  localparam logic [3:0] S_EMIT = 4'd11;

  // Configuration registers.
  logic [GW_BITS-1:0]   gw_r;
  logic [ROW_BITS-1:0]  gh_r;
  logic [GAIN_BITS-1:0] du_cfg_r, dv_cfg_r, f_r, k_r;
  logic [DT_BITS-1:0]   dt_r;

  // Control state.
  logic [3:0]          state_r, state_nxt;
  logic [XW-1:0]       col_r, x_r;
  logic [ROW_BITS-1:0] row_r, y_r;
  logic [1:0]          idx_r;
  logic [2:0]          emit_cnt_r;
  logic                last_r;
  logic                out_valid_r;

  // Payload.
  logic signed [VB-1:0] cur_u_r, cur_v_r;
  logic signed [VB-1:0] u_win_r [9];
  logic signed [VB-1:0] v_win_r [9];
  logic signed [LW-1:0] lapu_r, lapv_r;
  logic signed [VB-1:0] vv_r, uv2_r, un_r, vn_r;
  logic signed [AW-1:0] p1_r, p2_r, p3_r, p4_r, du_r, dv_r;
  logic [XW-1:0]        emit_col_r [MAX_EMIT];
  logic [ROW_BITS-1:0]  emit_row_r [MAX_EMIT];
  logic [COL_OUT_BITS-1:0] ocol_r;
  logic [ROW_BITS-1:0]  orow_r;
  logic [VB-1:0]        ou_r, ov_r;
  logic                 olast_r, ouser_r;

  // Effective frame size: width clamped to [3, MAX_WIDTH], height at least 3.
  logic [GW-1:0]       gw_ext;
  logic [CW-1:0]       w_eff;
  logic [ROW_BITS-1:0] h_eff, hm1, hm2;
  logic [XW-1:0]       wm1, wm2, x_eff;
  logic [ROW_BITS-1:0] y_eff;

  assign gw_ext = GW'(gw_r);
  always_comb begin
    if (gw_ext < GW'(3)) begin
      w_eff = CW'(3);
    end else if (gw_ext > GW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(gw_ext);
    end
  end
  assign h_eff = (gh_r < ROW_BITS'(3)) ? ROW_BITS'(3) : gh_r;
  assign wm1   = XW'(w_eff - CW'(1));
  assign wm2   = XW'(w_eff - CW'(2));
  assign hm1   = h_eff - ROW_BITS'(1);
  assign hm2   = h_eff - ROW_BITS'(2);
  assign x_eff = (CW'(col_r) >= w_eff) ? '0 : col_r;
  assign y_eff = (row_r >= h_eff) ? '0 : row_r;

  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Line stores: slot 0 holds the previous row, slot 1 the row before it.
  logic [2*VB-1:0] ram0_rd, ram1_rd;
  logic            rd_ph;
  logic            mid_ok, top_ok;
  assign rd_ph  = (state_r == S_RD);
  assign mid_ok = (y_r >= ROW_BITS'(1));
  assign top_ok = (y_r >= ROW_BITS'(2));

  rds_ram #(.WIDTH(2*VB), .DEPTH(MAX_WIDTH)) u_slot0 (
    .clk   (clk),
    .we    (rd_ph),
    .waddr (x_r),
    .wdata ({cur_v_r, cur_u_r}),
    .re    (in_acc),
    .raddr (x_eff),
    .rdata (ram0_rd)
  );

  rds_ram #(.WIDTH(2*VB), .DEPTH(MAX_WIDTH)) u_slot1 (
    .clk   (clk),
    .we    (rd_ph && mid_ok),
    .waddr (x_r),
    .wdata (ram0_rd),
    .re    (in_acc),
    .raddr (x_eff),
    .rdata (ram1_rd)
  );

  // Result coordinates of the interior cell that this input completes, in the
  // order: the cell itself, then left/right edge copies, then top and bottom
  // row copies with their corners. At most four are kept.
  logic [XW-1:0]       cx;
  logic [ROW_BITS-1:0] cy;
  logic                cand_en  [9];
  logic [XW-1:0]       cand_col [9];
  logic [ROW_BITS-1:0] cand_row [9];
  logic [XW-1:0]       list_col [MAX_EMIT];
  logic [ROW_BITS-1:0] list_row [MAX_EMIT];
  logic [2:0]          list_n;
  logic                cx_lo, cx_hi, cy_lo, cy_hi;

  assign cx    = x_r - XW'(1);
  assign cy    = y_r - ROW_BITS'(1);
  assign cx_lo = (cx == XW'(1));
  assign cx_hi = (cx == wm2);
  assign cy_lo = (cy == ROW_BITS'(1));
  assign cy_hi = (cy == hm2);

  always_comb begin
    cand_en[0] = 1'b1;          cand_col[0] = cx;  cand_row[0] = cy;
    cand_en[1] = cx_lo;         cand_col[1] = '0;  cand_row[1] = cy;
    cand_en[2] = cx_hi;         cand_col[2] = wm1; cand_row[2] = cy;
    cand_en[3] = cy_lo;         cand_col[3] = cx;  cand_row[3] = '0;
    cand_en[4] = cy_lo & cx_lo; cand_col[4] = '0;  cand_row[4] = '0;
    cand_en[5] = cy_lo & cx_hi; cand_col[5] = wm1; cand_row[5] = '0;
    cand_en[6] = cy_hi;         cand_col[6] = cx;  cand_row[6] = hm1;
    cand_en[7] = cy_hi & cx_lo; cand_col[7] = '0;  cand_row[7] = hm1;
    cand_en[8] = cy_hi & cx_hi; cand_col[8] = wm1; cand_row[8] = hm1;
    list_n = '0;
    for (int j = 0; j < MAX_EMIT; j++) begin
      list_col[j] = '0;
      list_row[j] = '0;
    end
    for (int i = 0; i < 9; i++) begin
      if (cand_en[i] && (list_n < 3'(MAX_EMIT))) begin
        list_col[list_n[1:0]] = cand_col[i];
        list_row[list_n[1:0]] = cand_row[i];
        list_n = list_n + 3'd1;
      end
    end
  end

  // Shared multiplier with rounding, followed by one saturator.
  logic signed [VB-1:0]   uc, vc;
  logic signed [AW-1:0]   mul_a;
  logic signed [BW-1:0]   mul_b;
  logic signed [VB-1:0]   addend;
  logic signed [PW-1:0]   prod_raw, prod_sh;
  logic signed [PW:0]     sat_in;
  logic signed [VB-1:0]   sat_out;
  logic [GAIN_BITS:0]     fk;

  assign uc = u_win_r[4];
  assign vc = v_win_r[4];
  assign fk = {1'b0, f_r} + {1'b0, k_r};

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    addend = '0;
    case (state_r)
      S_VV: begin
        mul_a = AW'(vc);
        mul_b = BW'(vc);
      end
      S_UV2: begin
        mul_a = AW'(uc);
        mul_b = BW'(vv_r);
      end
      S_P1: begin
        mul_a = AW'(lapu_r);
        mul_b = BW'($signed({1'b0, du_cfg_r}));
      end
      S_P2: begin
        mul_a = ONE_Q - AW'(uc);
        mul_b = BW'($signed({1'b0, f_r}));
      end
      S_P3: begin
        mul_a = AW'(lapv_r);
        mul_b = BW'($signed({1'b0, dv_cfg_r}));
      end
      S_P4: begin
        mul_a = AW'(vc);
        mul_b = BW'($signed({1'b0, fk}));
      end
      S_UN: begin
        mul_a  = du_r;
        mul_b  = BW'($signed({1'b0, dt_r}));
        addend = uc;
      end
      S_VN: begin
        mul_a  = dv_r;
        mul_b  = BW'($signed({1'b0, dt_r}));
        addend = vc;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Round half up: add one half, then an arithmetic shift floors.
  assign prod_raw = PW'(mul_a) * PW'(mul_b);
  assign prod_sh  = (prod_raw + HALF_Q) >>> FRAC_BITS;
  assign sat_in   = (PW+1)'(prod_sh) + (PW+1)'(addend);

  always_comb begin
    if (sat_in > SAT_HI) begin
      sat_out = VB'(SAT_HI);
    end else if (sat_in < SAT_LO) begin
      sat_out = VB'(SAT_LO);
    end else begin
      sat_out = sat_in[VB-1:0];
    end
  end

  // Sequencer.
  logic emit_load, emit_final;
  assign emit_load  = (state_r == S_EMIT) && (!out_valid_r || out_tready);
  assign emit_final = (({1'b0, idx_r} + 3'd1) == emit_cnt_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_RD;
      S_RD: begin
        if ((x_r >= XW'(2)) && top_ok) begin
          state_nxt = S_VV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_VV:   state_nxt = S_UV2;
      S_UV2:  state_nxt = S_P1;
      S_P1:   state_nxt = S_P2;
      S_P2:   state_nxt = S_P3;
      S_P3:   state_nxt = S_P4;
      S_P4:   state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_UN;
      S_UN:   state_nxt = S_VN;
      S_VN:   state_nxt = S_EMIT;
      S_EMIT: if (emit_load && emit_final) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      idx_r       <= '0;
      emit_cnt_r  <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      gw_r        <= GRID_WIDTH_RST;
      gh_r        <= GRID_HEIGHT_RST;
      du_cfg_r    <= DIFF_U_RST;
      dv_cfg_r    <= DIFF_V_RST;
      f_r         <= FEED_RST;
      k_r         <= KILL_RST;
      dt_r        <= DT_RST;
      for (int i = 0; i < 9; i++) begin
        u_win_r[i] <= '0;
        v_win_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (rd_ph) begin
        for (int r = 0; r < 3; r++) begin
          u_win_r[r*3]   <= u_win_r[r*3+1];
          u_win_r[r*3+1] <= u_win_r[r*3+2];
          v_win_r[r*3]   <= v_win_r[r*3+1];
          v_win_r[r*3+1] <= v_win_r[r*3+2];
        end
        u_win_r[2] <= top_ok ? $signed(ram1_rd[VB-1:0]) : '0;
        v_win_r[2] <= top_ok ? $signed(ram1_rd[2*VB-1:VB]) : '0;
        u_win_r[5] <= mid_ok ? $signed(ram0_rd[VB-1:0]) : '0;
        v_win_r[5] <= mid_ok ? $signed(ram0_rd[2*VB-1:VB]) : '0;
        u_win_r[8] <= cur_u_r;
        v_win_r[8] <= cur_v_r;
        emit_cnt_r <= list_n;
        last_r     <= (x_r == wm1) && (y_r == hm1);
        // Advance the raster position.
        if (x_r == wm1) begin
          col_r <= '0;
          row_r <= (y_r == hm1) ? '0 : y_r + ROW_BITS'(1);
        end else begin
          col_r <= x_r + XW'(1);
          row_r <= y_r;
        end
      end

      if (state_r == S_VN) begin
        idx_r <= '0;
      end else if (emit_load) begin
        idx_r <= idx_r + 2'd1;
      end

      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      // A size change restarts the frame at the first cell.
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_WIDTH: begin
            gw_r  <= cfg_wdata[GW_BITS-1:0];
            col_r <= '0;
            row_r <= '0;
          end
          REG_GRID_HEIGHT: begin
            gh_r  <= cfg_wdata[ROW_BITS-1:0];
            col_r <= '0;
            row_r <= '0;
          end
          REG_DIFFUSION_U: du_cfg_r <= cfg_wdata[GAIN_BITS-1:0];
          REG_DIFFUSION_V: dv_cfg_r <= cfg_wdata[GAIN_BITS-1:0];
          REG_FEED_RATE:   f_r      <= cfg_wdata[GAIN_BITS-1:0];
          REG_KILL_RATE:   k_r      <= cfg_wdata[GAIN_BITS-1:0];
          REG_TIME_STEP:   dt_r     <= cfg_wdata[DT_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_u_r <= $signed(in_tdata[VB-1:0]);
      cur_v_r <= $signed(in_tdata[2*VB-1:VB]);
      x_r     <= x_eff;
      y_r     <= y_eff;
    end
    if (rd_ph) begin
      for (int j = 0; j < MAX_EMIT; j++) begin
        emit_col_r[j] <= list_col[j];
        emit_row_r[j] <= list_row[j];
      end
    end
    case (state_r)
      S_VV: begin
        vv_r   <= sat_out;
        lapu_r <= LW'(u_win_r[1]) + LW'(u_win_r[7]) + LW'(u_win_r[3]) + LW'(u_win_r[5])
                  - (LW'(uc) <<< LAP_SHIFT);
        lapv_r <= LW'(v_win_r[1]) + LW'(v_win_r[7]) + LW'(v_win_r[3]) + LW'(v_win_r[5])
                  - (LW'(vc) <<< LAP_SHIFT);
      end
      S_UV2: uv2_r <= sat_out;
      S_P1:  p1_r  <= prod_sh[AW-1:0];
      S_P2:  p2_r  <= prod_sh[AW-1:0];
      S_P3:  p3_r  <= prod_sh[AW-1:0];
      S_P4:  p4_r  <= prod_sh[AW-1:0];
      S_DIFF: begin
        du_r <= p1_r - AW'(uv2_r) + p2_r;
        dv_r <= p3_r + AW'(uv2_r) - p4_r;
      end
      S_UN:  un_r <= sat_out;
      S_VN:  vn_r <= sat_out;
      default: ;
    endcase
    if (emit_load) begin
      ocol_r  <= COL_OUT_BITS'(emit_col_r[idx_r]);
      orow_r  <= emit_row_r[idx_r];
      ou_r    <= un_r;
      ov_r    <= vn_r;
      olast_r <= emit_final;
      ouser_r <= emit_final && last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TW'({ov_r, ou_r, orow_r, ocol_r});
  assign out_tlast  = olast_r;
  assign out_tuser  = ouser_r;

  `RDS_ASSERT_IMPL(a_rd_after_accept, state_r == S_RD, $past(in_tvalid && in_tready), "line store read phase without an accepted request")
  `RDS_ASSERT_IMPL(a_frame_end_is_run_end, out_tvalid && out_tuser, out_tlast, "frame end on a result that is not the last of its cell")
  `RDS_ASSERT_NEXT(a_emit_starts_clean, state_r == S_VN, (state_r == S_EMIT) && (idx_r == 2'd0) && (emit_cnt_r != 3'd0), "emit phase entered with bad index or count")
endmodule
